// File: hdl/lsbse_pkg.sv
// Shared types, constants and a helper function for the LSB message extractor.
`timescale 1ns / 1ps

package lsbse_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned FW_W           = 13;
  localparam int unsigned MV_W           = 17;
  localparam int unsigned CODE_W         = 16;
  localparam int unsigned IDX_W          = 8;
  localparam int unsigned CFG_IDX_W      = 8;
  localparam int unsigned LEN_BITS       = 8;
  localparam int unsigned WIN_W          = 17;
  localparam int unsigned UCNT_W         = 5;
  localparam int unsigned BITCNT_W       = 4;
  localparam int unsigned RES_FIFO_DEPTH = 4;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 13'd500;
  localparam logic [MV_W-1:0] MARKER_RST      = 17'd69420;
  localparam logic [16:0]     MIN_WIDTH       = 17'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 8'd0,
    CFG_MARKER_VALUE = 8'd1
  } cfg_reg_t;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             item_kind;
    logic [CODE_W-1:0] char_code;
    logic [IDX_W-1:0]  char_index;
    logic              marker_ok;
    logic              last_of_frame;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       res_a;
    res_t       res_b;
  } push_t;

  function automatic logic [16:0] clamp_width(logic [FW_W-1:0] fw, logic [16:0] max_w);
    logic [16:0] w;
    w = {4'd0, fw};
    if (w < MIN_WIDTH) begin
      w = MIN_WIDTH;
    end else if (w > max_w) begin
      w = max_w;
    end
    return w;
  endfunction

endpackage

// File: hdl/lsbse_if.sv
// Valid/ready channel interfaces for pixel input, result output and register writes.
`timescale 1ns / 1ps

interface lsbse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_blue;
  logic       usable;
  logic       frame_end;

  modport source (output valid, pixel_blue, usable, frame_end, input ready);
  modport sink (input valid, pixel_blue, usable, frame_end, output ready);
endinterface

interface lsbse_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [15:0] char_code;
  logic [7:0]  char_index;
  logic        marker_ok;
  logic        last_of_frame;

  modport source (output valid, item_kind, char_code, char_index, marker_ok, last_of_frame,
                  input ready);
  modport sink (input valid, item_kind, char_code, char_index, marker_ok, last_of_frame,
                output ready);
endinterface

interface lsbse_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/lsbse_res_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one per beat.
`timescale 1ns / 1ps

module lsbse_res_fifo #(
  parameter int unsigned DEPTH = lsbse_pkg::RES_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lsbse_pkg::push_t   push,
  output logic               room,
  lsbse_out_if.source        out_bus
);
  import lsbse_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);

  res_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic [PW:0]   cnt_nxt;
  logic          pop;
  res_t          head;

  assign pop  = out_bus.valid & out_bus.ready;
  assign room = (cnt_r <= (PW+1)'(DEPTH - 2));

  always_comb begin
    cnt_nxt = cnt_r + (PW+1)'(push.cnt) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(push.cnt);
      rd_ptr_r <= rd_ptr_r + PW'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res_a;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + PW'(1)] <= push.res_b;
    end
  end

  assign head                  = mem_r[rd_ptr_r];
  assign out_bus.valid         = (cnt_r != '0);
  assign out_bus.item_kind     = head.item_kind;
  assign out_bus.char_code     = head.char_code;
  assign out_bus.char_index    = head.char_index;
  assign out_bus.marker_ok     = head.marker_ok;
  assign out_bus.last_of_frame = head.last_of_frame;

endmodule

// File: hdl/lsb_stego_message_extract.sv
// Top level of the LSB steganography message extractor.
`timescale 1ns / 1ps
//
// Pixels arrive in raster order on in_bus, one beat per pixel, carrying the blue
// byte, the usable bit and frame_end. The first eight pixels of row 0 give the
// message length, MSB first. From row 1 on, the blue LSBs of usable pixels build
// 16-bit characters, and each finished character leaves on out_bus as a beat of
// kind character. The pixel that carries frame_end also yields a verdict beat
// that reports the character count and whether the last 17 usable LSBs equal
// marker_value, after which all frame state returns to its reset value.
// cfg_bus writes frame_width (index 0) and marker_value (index 1); it is always
// ready and should be used only while no pixel is in flight.
// A pixel is processed in the cycle it is accepted, and its results are written
// into the result queue that drives out_bus. The block takes one pixel per cycle;
// a pixel that yields both a character and a verdict puts two beats into that
// four-entry queue, and in_bus.ready drops only while the queue has fewer than
// two free entries, which happens when the receiver stalls. Synchronous reset
// empties the queue and restores the reset register values and frame state.
//

module lsb_stego_message_extract #(
  parameter int unsigned MAX_WIDTH = lsbse_pkg::DEF_MAX_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  lsbse_in_if.sink     in_bus,
  lsbse_out_if.source  out_bus,
  lsbse_cfg_if.sink    cfg_bus
);
  import lsbse_pkg::*;

  localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
  localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);
  localparam logic [16:0] RST_W17 = clamp_width(FRAME_WIDTH_RST, MAX_W17);

  logic [WW-1:0]       width_r;
  logic [MV_W-1:0]     marker_r;
  logic [WW-1:0]       column_r, column_nxt;
  logic                first_row_r, first_row_nxt;
  logic [IDX_W-1:0]    msg_len_r, msg_len_nxt;
  logic [CODE_W-1:0]   char_shift_r, char_shift_nxt;
  logic [BITCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [IDX_W-1:0]    chars_done_r, chars_done_nxt;
  logic [WIN_W-1:0]    window_r, window_nxt;
  logic [UCNT_W-1:0]   ucnt_r, ucnt_nxt;

  logic                accept;
  logic                room;
  logic                pix_bit;
  logic [CODE_W-1:0]   code;
  logic                char_fire;
  logic                verdict_fire;
  logic [16:0]         cfg_w17;
  res_t                char_res;
  res_t                verdict_res;
  push_t               push;

  assign in_bus.ready  = room;
  assign cfg_bus.ready = 1'b1;
  assign accept        = in_bus.valid & in_bus.ready;
  assign pix_bit       = in_bus.pixel_blue[0];
  assign cfg_w17       = clamp_width(cfg_bus.data[FW_W-1:0], MAX_W17);

  always_comb begin
    column_nxt     = column_r;
    first_row_nxt  = first_row_r;
    msg_len_nxt    = msg_len_r;
    char_shift_nxt = char_shift_r;
    bit_cnt_nxt    = bit_cnt_r;
    chars_done_nxt = chars_done_r;
    window_nxt     = window_r;
    ucnt_nxt       = ucnt_r;
    code           = {char_shift_r[CODE_W-2:0], pix_bit};
    char_fire      = 1'b0;
    verdict_fire   = in_bus.frame_end;

    if (first_row_r) begin
      if (column_r < WW'(LEN_BITS)) begin
        msg_len_nxt = {msg_len_r[IDX_W-2:0], pix_bit};
      end
    end else if (in_bus.usable && (chars_done_r < msg_len_r)) begin
      char_shift_nxt = code;
      bit_cnt_nxt    = bit_cnt_r + 1'b1;
      if (bit_cnt_nxt == '0) begin
        char_fire      = 1'b1;
        chars_done_nxt = chars_done_r + 1'b1;
        char_shift_nxt = '0;
      end
    end

    if (in_bus.usable) begin
      window_nxt = {pix_bit, window_r[WIN_W-1:1]};
      if (ucnt_r < UCNT_W'(WIN_W)) begin
        ucnt_nxt = ucnt_r + 1'b1;
      end
    end

    if (({1'b0, column_r} + 1'b1) >= {1'b0, width_r}) begin
      column_nxt    = '0;
      first_row_nxt = 1'b0;
    end else begin
      column_nxt = column_r + 1'b1;
    end

    char_res.item_kind     = KIND_CHAR;
    char_res.char_code     = code;
    char_res.char_index    = chars_done_r;
    char_res.marker_ok     = 1'b0;
    char_res.last_of_frame = 1'b0;

    verdict_res.item_kind     = KIND_VERDICT;
    verdict_res.char_code     = '0;
    verdict_res.char_index    = chars_done_nxt;
    verdict_res.marker_ok     = (ucnt_nxt == UCNT_W'(WIN_W)) && (window_nxt == marker_r);
    verdict_res.last_of_frame = 1'b1;

    if (verdict_fire) begin
      column_nxt     = '0;
      first_row_nxt  = 1'b1;
      msg_len_nxt    = '0;
      char_shift_nxt = '0;
      bit_cnt_nxt    = '0;
      chars_done_nxt = '0;
      window_nxt     = '0;
      ucnt_nxt       = '0;
    end

    push.cnt   = accept ? (2'(char_fire) + 2'(verdict_fire)) : 2'd0;
    push.res_a = char_fire ? char_res : verdict_res;
    push.res_b = verdict_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= RST_W17[WW-1:0];
      marker_r     <= MARKER_RST;
      column_r     <= '0;
      first_row_r  <= 1'b1;
      msg_len_r    <= '0;
      char_shift_r <= '0;
      bit_cnt_r    <= '0;
      chars_done_r <= '0;
      window_r     <= '0;
      ucnt_r       <= '0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        unique case (cfg_bus.index)
          CFG_FRAME_WIDTH:  width_r  <= cfg_w17[WW-1:0];
          CFG_MARKER_VALUE: marker_r <= cfg_bus.data;
          default: ;
        endcase
      end
      if (accept) begin
        column_r     <= column_nxt;
        first_row_r  <= first_row_nxt;
        msg_len_r    <= msg_len_nxt;
        char_shift_r <= char_shift_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        chars_done_r <= chars_done_nxt;
        window_r     <= window_nxt;
        ucnt_r       <= ucnt_nxt;
      end
    end
  end

  lsbse_res_fifo #(
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_bus (out_bus)
  );

endmodule

// File: hdl/lsbse_checker.sv
// Port-level checker for the LSB message extractor and its bind to the top level.
`timescale 1ns / 1ps

module lsbse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_usable,
  input logic        in_frame_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_item_kind,
  input logic [15:0] out_char_code,
  input logic [7:0]  out_char_index
);

  // A stalled result beat keeps its contents.
  ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_kind) &&
      $stable(out_char_code) && $stable(out_char_index))
    else $error("result beat changed while stalled");

  // Reset leaves the result channel empty.
  ap_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // While the result channel is empty, a frame end pixel produces a result beat in the next cycle.
  ap_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_end && !out_valid |=> out_valid)
    else $error("no result after frame end pixel");

  // A pixel that can carry no bit and ends no frame yields nothing.
  ap_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_usable && !in_frame_end && !out_valid |=> !out_valid)
    else $error("result from a pixel that cannot produce one");

endmodule

bind lsb_stego_message_extract lsbse_checker u_lsbse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_usable      (in_bus.usable),
  .in_frame_end   (in_bus.frame_end),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_item_kind  (out_bus.item_kind),
  .out_char_code  (out_bus.char_code),
  .out_char_index (out_bus.char_index)
);

// File: verif/lsb_stego_message_extract_tb.sv
// Self-checking testbench for lsb_stego_message_extract with directed and random pixel streams.
`timescale 1ns / 1ps

module lsb_stego_message_extract_tb;
  import lsbse_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] blue;
    logic       usable;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    pixel_t px;
    logic   typed;
    res_t   verdict;
  } dir_row_t;

  typedef struct packed {
    logic [11:0] col;
    logic        first_row;
    logic [7:0]  msg_len;
    logic [15:0] code_shift;
    logic [3:0]  nbits;
    logic [7:0]  nchars;
    logic [16:0] window;
    logic [4:0]  nusable;
  } frame_state_t;

  typedef enum logic [1:0] {
    FRAMES_MIXED,
    FRAMES_ONE_LONG,
    FRAMES_BROKEN
  } phase_mode_t;

  typedef struct packed {
    logic [12:0] width;
    logic [16:0] marker;
    logic        random_marker;
    phase_mode_t mode;
    logic [15:0] budget;
  } phase_t;

  localparam frame_state_t FRAME_CLEAR = '{12'd0, 1'b1, 8'd0, 16'd0, 4'd0, 8'd0, 17'd0, 5'd0};
  localparam res_t NO_RESULT    = '0;
  localparam res_t VERDICT_MISS = '{KIND_VERDICT, 16'd0, 8'd0, 1'b0, 1'b1};
  localparam res_t VERDICT_HIT  = '{KIND_VERDICT, 16'd0, 8'd0, 1'b1, 1'b1};

  logic clk;
  logic rst_n;

  lsbse_in_if  in_bus();
  lsbse_out_if out_bus();
  lsbse_cfg_if cfg_bus();

  lsb_stego_message_extract dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  logic [FW_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [MV_W-1:0] marker_reg = MARKER_RST;
  frame_state_t    frame      = FRAME_CLEAR;
  res_t            pending_results[$];

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned pixels_sent = 0;
  bit          jitter_on = 1'b1;
  logic        row_has_verdict;
  res_t        row_verdict;

  // The first frame is a lone frame_end pixel. The second carries the reset
  // marker in 17 usable pixels of row 0, with one unusable pixel in between.
  dir_row_t directed_rows [21] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, VERDICT_MISS},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFE, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b1}, 1'b1, VERDICT_HIT},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b1, 1'b1}, 1'b1, VERDICT_MISS}
  };

  phase_t phase_plan [10] = '{
    '{13'd8,    17'd0,      1'b0, FRAMES_MIXED,    16'd65},
    '{13'd11,   17'h1FFFF,  1'b0, FRAMES_MIXED,    16'd65},
    '{13'd0,    17'd0,      1'b1, FRAMES_MIXED,    16'd65},
    '{13'd20,   17'd0,      1'b1, FRAMES_MIXED,    16'd65},
    '{13'd9,    17'd69420,  1'b0, FRAMES_MIXED,    16'd65},
    '{13'd8191, 17'd0,      1'b1, FRAMES_BROKEN,   16'd40},
    '{13'd4096, 17'd0,      1'b1, FRAMES_BROKEN,   16'd40},
    '{13'd14,   17'd0,      1'b1, FRAMES_MIXED,    16'd65},
    '{13'd3,    17'd0,      1'b1, FRAMES_MIXED,    16'd65},
    '{13'd8,    17'h1FFFF,  1'b0, FRAMES_MIXED,    16'd65}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < 8) w = 8;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    return w;
  endfunction

  function automatic void decode_pixel(pixel_t px);
    logic b;
    b = px.blue[0];
    if (frame.first_row) begin
      if (frame.col < 12'd8) frame.msg_len = {frame.msg_len[6:0], b};
    end else if (px.usable && frame.nchars < frame.msg_len) begin
      frame.code_shift = {frame.code_shift[14:0], b};
      frame.nbits = frame.nbits + 4'd1;
      if (frame.nbits == 4'd0) begin
        pending_results.push_back('{KIND_CHAR, frame.code_shift, frame.nchars, 1'b0, 1'b0});
        frame.nchars = frame.nchars + 8'd1;
        frame.code_shift = 16'd0;
      end
    end
    if (px.usable) begin
      frame.window = {b, frame.window[16:1]};
      if (frame.nusable < 5'd17) frame.nusable = frame.nusable + 5'd1;
    end
    if (32'(frame.col) + 32'd1 >= eff_width()) begin
      frame.col = 12'd0;
      frame.first_row = 1'b0;
    end else begin
      frame.col = frame.col + 12'd1;
    end
    if (px.frame_end) begin
      pending_results.push_back('{KIND_VERDICT, 16'd0, frame.nchars,
                                  frame.nusable >= 5'd17 && frame.window == marker_reg, 1'b1});
      frame = FRAME_CLEAR;
    end
  endfunction

  function automatic void check_result(res_t got);
    res_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing expected: kind %0d code %h index %0d",
             got.item_kind, got.char_code, got.char_index);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    if (got.item_kind !== want.item_kind) begin
      $error("item_kind: expected %0d, got %0d", want.item_kind, got.item_kind);
      mismatches++;
    end
    if (got.char_code !== want.char_code) begin
      $error("char_code: expected %h, got %h", want.char_code, got.char_code);
      mismatches++;
    end
    if (got.char_index !== want.char_index) begin
      $error("char_index: expected %0d, got %0d", want.char_index, got.char_index);
      mismatches++;
    end
    if (got.marker_ok !== want.marker_ok) begin
      $error("marker_ok: expected %0d, got %0d", want.marker_ok, got.marker_ok);
      mismatches++;
    end
    if (got.last_of_frame !== want.last_of_frame) begin
      $error("last_of_frame: expected %0d, got %0d", want.last_of_frame, got.last_of_frame);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        case (cfg_reg_t'(cfg_bus.index))
          CFG_FRAME_WIDTH:  width_reg = cfg_bus.data[FW_W-1:0];
          CFG_MARKER_VALUE: marker_reg = cfg_bus.data;
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        moved = 1'b1;
        decode_pixel({in_bus.pixel_blue, in_bus.usable, in_bus.frame_end});
        if (row_has_verdict) pending_results[$] = row_verdict;
      end
      if (out_bus.valid && out_bus.ready) begin
        moved = 1'b1;
        check_result('{kind_t'(out_bus.item_kind), out_bus.char_code, out_bus.char_index,
                       out_bus.marker_ok, out_bus.last_of_frame});
      end
    end
    quiet_cycles <= moved ? 0 : quiet_cycles + 1;
  end

  always @(negedge clk) begin
    out_bus.ready = !(jitter_on && $urandom_range(0, 99) < 10);
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("lsb_stego_message_extract_tb: FAIL");
    $finish;
  end

  task automatic send_pixel(input pixel_t px, input logic typed, input res_t verdict);
    while (jitter_on && $urandom_range(0, 99) < 10) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid      = 1'b1;
    in_bus.pixel_blue = px.blue;
    in_bus.usable     = px.usable;
    in_bus.frame_end  = px.frame_end;
    row_has_verdict   = typed;
    row_verdict       = verdict;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [16:0] value);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // A well-formed frame puts the length in row 0 and usable pixels for up to four characters
  // after it, optionally ending on the marker. Others are cut short or left open.
  task automatic run_frame(input phase_mode_t mode);
    int unsigned w, roll, len, nchr, nuse, k, cnt;
    bit hit;
    pixel_t px;
    w = eff_width();
    case (mode)
      FRAMES_ONE_LONG: roll = 0;
      FRAMES_BROKEN:   roll = $urandom_range(70, 99);
      default:         roll = $urandom_range(0, 99);
    endcase
    if (roll < 70) begin
      case ($urandom_range(0, 9))
        0:       len = 255;
        1:       len = $urandom_range(0, 255);
        default: len = $urandom_range(0, 4);
      endcase
      nchr = (len <= 4) ? len : $urandom_range(0, 3);
      hit = 1'($urandom_range(0, 1));
      nuse = 16 * nchr + $urandom_range(0, 20);
      if (hit && nuse < 17) nuse = 17;
      for (k = 0; k < w; k++) begin
        px.blue = 8'($urandom);
        if (k < 8) px.blue[0] = len[7 - k];
        px.usable = 1'($urandom_range(0, 1));
        px.frame_end = 1'b0;
        send_pixel(px, 1'b0, NO_RESULT);
      end
      k = 0;
      while (k < nuse) begin
        px.blue = 8'($urandom);
        px.usable = ($urandom_range(0, 3) != 0);
        px.frame_end = 1'b0;
        if (px.usable) begin
          if (hit && k + 17 >= nuse) px.blue[0] = marker_reg[k + 17 - nuse];
          k++;
          if (k == nuse && $urandom_range(0, 1)) px.frame_end = 1'b1;
        end
        send_pixel(px, 1'b0, NO_RESULT);
      end
      if (!px.frame_end) begin
        px.blue = 8'($urandom);
        px.usable = 1'b0;
        px.frame_end = 1'b1;
        send_pixel(px, 1'b0, NO_RESULT);
      end
    end else begin
      cnt = (roll < 85) ? $urandom_range(1, (w > 44) ? 64 : w + 20) : $urandom_range(1, 40);
      for (k = 1; k <= cnt; k++) begin
        px.blue = 8'($urandom);
        px.usable = 1'($urandom_range(0, 1));
        px.frame_end = (roll < 85) && (k == cnt);
        send_pixel(px, 1'b0, NO_RESULT);
      end
    end
  endtask

  initial begin
    int unsigned start;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.pixel_blue = 8'd0;
    in_bus.usable     = 1'b0;
    in_bus.frame_end  = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_FRAME_WIDTH;
    cfg_bus.data      = 17'd0;
    out_bus.ready     = 1'b1;
    row_has_verdict   = 1'b0;
    row_verdict       = NO_RESULT;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].verdict);
    end
    row_has_verdict = 1'b0;

    foreach (phase_plan[p]) begin
      in_bus.valid = 1'b0;
      wait_idle();
      jitter_on = (p >= 2);
      write_reg(CFG_FRAME_WIDTH, 17'(phase_plan[p].width));
      write_reg(CFG_MARKER_VALUE, phase_plan[p].random_marker ?
                17'($urandom_range(0, 131071)) : phase_plan[p].marker);
      start = pixels_sent;
      do begin
        run_frame(phase_plan[p].mode);
      end while (phase_plan[p].mode != FRAMES_ONE_LONG &&
                 pixels_sent - start < phase_plan[p].budget);
      if (phase_plan[p].mode == FRAMES_MIXED && $urandom_range(0, 2) == 0) begin
        run_frame(FRAMES_BROKEN);
      end
    end

    in_bus.valid = 1'b0;
    wait_idle();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("lsb_stego_message_extract_tb: PASS");
    end else begin
      $display("lsb_stego_message_extract_tb: FAIL");
    end
    $finish;
  end

endmodule
